/* src/assert_macros.svh */
// assertion macros for the rtl, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication, clocked on clk, off during rst
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

/* src/bmd_pkg.sv */
// shared widths, register codes and glyph lookup for the block max downscaler
`timescale 1ns / 1ps
`default_nettype none

package bmd_pkg;

  localparam int PIXEL_W       = 8;
  localparam int GLYPH_W       = 7;
  localparam int OUT_COL_W     = 10;
  localparam int OUT_ROW_W     = 12;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_INDEX_W   = 3;
  localparam int COLS_REG_W    = 11;
  localparam int OUT_ROWS_LIMIT = 4096;
  localparam int ROW_CNT_W     = 13;
  localparam int GLYPH_DIVISOR = 43;
  localparam int GLYPH_ENTRIES = 6;

  typedef logic [PIXEL_W-1:0]    pixel_t;
  typedef logic [GLYPH_W-1:0]    glyph_t;
  typedef logic [OUT_COL_W-1:0]  out_col_t;
  typedef logic [OUT_ROW_W-1:0]  out_row_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_BLOCK_WIDTH  = 3'd2,
    REG_BLOCK_HEIGHT = 3'd3,
    REG_OUT_COLUMNS  = 3'd4,
    REG_OUT_ROWS     = 3'd5
  } cfg_reg_t;

  localparam glyph_t GLYPH_ZERO = 7'h2e;
  localparam glyph_t GLYPH_TABLE [GLYPH_ENTRIES] = '{7'h2c, 7'h3a, 7'h6f, 7'h4f, 7'h40, 7'h23};

  // value / 43 by threshold compares, zero maps to a dot
  function automatic glyph_t glyph_of(pixel_t m);
    logic [2:0] sel;
    sel = 3'd0;
    for (int k = 1; k < GLYPH_ENTRIES; k++) begin
      if (32'(m) >= GLYPH_DIVISOR * k) begin
        sel = sel + 3'd1;
      end
    end
    if (m == '0) begin
      return GLYPH_ZERO;
    end
    return GLYPH_TABLE[sel];
  endfunction

endpackage

`default_nettype wire

/* src/bmd_if.sv */
// handshake channels of the block max downscaler: pixels, results, config writes
`timescale 1ns / 1ps
`default_nettype none

interface bmd_pixel_if;
  logic            valid;
  logic            ready;
  bmd_pkg::pixel_t pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface bmd_result_if;
  logic              valid;
  logic              ready;
  bmd_pkg::pixel_t   block_max;
  bmd_pkg::glyph_t   glyph;
  bmd_pkg::out_col_t out_col;
  bmd_pkg::out_row_t out_row;
  logic              frame_last;
  modport source (output valid, output block_max, output glyph, output out_col,
                  output out_row, output frame_last, input ready);
  modport sink (input valid, input block_max, input glyph, input out_col,
                input out_row, input frame_last, output ready);
endinterface

interface bmd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [bmd_pkg::CFG_INDEX_W-1:0]     index;
  bmd_pkg::cfg_data_t                  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/bmd_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module bmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/block_max_downscaler.sv */
// top level of the block max downscaler: position tracking, line store update, result register
`timescale 1ns / 1ps
`default_nettype none

// Max-pooling downscaler. Pixels of a frame enter in raster order, one beat per clock
// sustained, and each block of the configured grid yields one result beat (its maximum,
// an ASCII glyph, its grid position and a last-of-frame flag) once its bottom-right
// pixel is accepted, by way of the compare stage and the result register. A running
// maximum per output column lives in a single-port-write, single-port-read line store:
// the read is issued as a pixel is accepted, the compare and write-back happen in the
// compare stage from the registered read data, and a bypass of the most recent write
// covers back-to-back pixels of the same column, so the store's one read and one write
// port set the one-pixel-per-clock rate. Results sit in an output register; pixels keep
// flowing while a result waits, and the input stalls only when a second result is due
// before the first is taken. Pixels right of or below the grid are dropped. The store
// needs no clearing after reset since every block loads it on its first pixel. Register
// writes take effect at once and are meant for idle periods.

`include "assert_macros.svh"

module block_max_downscaler #(
  parameter int MAX_OUT_COLUMNS = 1024,
  parameter int MAX_IMAGE_DIM   = 4096
) (
  input  logic          clk,
  input  logic          rst,
  bmd_pixel_if.sink     pixels,
  bmd_result_if.source  results,
  bmd_cfg_if.sink       cfg
);

  localparam int DATA_W    = bmd_pkg::CFG_DATA_W;
  localparam int CREG_W    = bmd_pkg::COLS_REG_W;
  localparam int ROW_W     = bmd_pkg::ROW_CNT_W;
  localparam int OCW       = bmd_pkg::OUT_COL_W;
  localparam int ORW       = bmd_pkg::OUT_ROW_W;
  localparam int DIM_W     = $clog2(MAX_IMAGE_DIM + 1);
  localparam int COL_W     = $clog2(MAX_OUT_COLUMNS + 1);
  localparam int ADDR_W    = (MAX_OUT_COLUMNS > 1) ? $clog2(MAX_OUT_COLUMNS) : 1;
  localparam int DIM_CMP_W = (DIM_W > DATA_W) ? DIM_W : DATA_W;
  localparam int COL_CMP_W = (COL_W > CREG_W) ? COL_W : CREG_W;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DATA_W-1:0] v);
    logic [DIM_CMP_W-1:0] w;
    w = DIM_CMP_W'(v);
    if (w == '0) begin
      w = DIM_CMP_W'(1);
    end else if (w > DIM_CMP_W'(MAX_IMAGE_DIM)) begin
      w = DIM_CMP_W'(MAX_IMAGE_DIM);
    end
    return DIM_W'(w);
  endfunction

  function automatic logic [COL_W-1:0] clamp_cols(logic [CREG_W-1:0] v);
    logic [COL_CMP_W-1:0] w;
    w = COL_CMP_W'(v);
    if (w == '0) begin
      w = COL_CMP_W'(1);
    end else if (w > COL_CMP_W'(MAX_OUT_COLUMNS)) begin
      w = COL_CMP_W'(MAX_OUT_COLUMNS);
    end
    return COL_W'(w);
  endfunction

  function automatic logic [ROW_W-1:0] clamp_rows(logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] w;
    w = v;
    if (w == '0) begin
      w = DATA_W'(1);
    end else if (w > DATA_W'(bmd_pkg::OUT_ROWS_LIMIT)) begin
      w = DATA_W'(bmd_pkg::OUT_ROWS_LIMIT);
    end
    return ROW_W'(w);
  endfunction

  // configuration registers, raw as written
  logic [DATA_W-1:0] image_width, image_height, block_width, block_height, out_rows;
  logic [CREG_W-1:0] out_columns;

  logic [DIM_W-1:0] iw, ih, bw, bh;
  logic [COL_W-1:0] oc;
  logic [ROW_W-1:0] orr;

  // position of the next pixel
  logic [DIM_W-1:0] pixel_column, pixel_row, offset_x, offset_y;
  logic [DIM_W-1:0] pixel_column_next, pixel_row_next, offset_x_next, offset_y_next;
  logic [COL_W-1:0] block_column, block_column_next;
  logic [ROW_W-1:0] block_row, block_row_next;

  logic [DIM_W-1:0] ox_inc, oy_inc;
  logic             in_grid, first_pixel, last_pixel, grid_last;
  logic             accept;

  // compare stage
  logic                s1_valid, s1_fire, s1_first, s1_emit, s1_wr, s1_frame_last;
  bmd_pkg::pixel_t     s1_px;
  logic [ADDR_W-1:0]   s1_addr;
  bmd_pkg::out_col_t   s1_col;
  bmd_pkg::out_row_t   s1_row;

  // last write, for the read-during-write bypass
  logic                lw_valid;
  logic [ADDR_W-1:0]   lw_addr;
  bmd_pkg::pixel_t     lw_data;

  bmd_pkg::pixel_t     ram_rdata, stored, blk_max;
  logic                ram_we;

  // result register
  logic                res_valid, res_frame_last, out_free;
  bmd_pkg::pixel_t     res_max;
  bmd_pkg::glyph_t     res_glyph;
  bmd_pkg::out_col_t   res_col;
  bmd_pkg::out_row_t   res_row;

  assign iw  = clamp_dim(image_width);
  assign ih  = clamp_dim(image_height);
  assign bw  = clamp_dim(block_width);
  assign bh  = clamp_dim(block_height);
  assign oc  = clamp_cols(out_columns);
  assign orr = clamp_rows(out_rows);

  assign cfg.ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DATA_W'(256);
      image_height <= DATA_W'(256);
      block_width  <= DATA_W'(32);
      block_height <= DATA_W'(32);
      out_columns  <= CREG_W'(8);
      out_rows     <= DATA_W'(8);
    end else if (cfg.valid && cfg.ready) begin
      unique case (bmd_pkg::cfg_reg_t'(cfg.index))
        bmd_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        bmd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.data;
        bmd_pkg::REG_BLOCK_WIDTH:  block_width  <= cfg.data;
        bmd_pkg::REG_BLOCK_HEIGHT: block_height <= cfg.data;
        bmd_pkg::REG_OUT_COLUMNS:  out_columns  <= cfg.data[CREG_W-1:0];
        bmd_pkg::REG_OUT_ROWS:     out_rows     <= cfg.data;
        default: ;
      endcase
    end
  end

  assign out_free     = ~res_valid | results.ready;
  assign s1_fire      = s1_valid & (~s1_emit | out_free);
  assign pixels.ready = ~rst & (~s1_valid | s1_fire);
  assign accept       = pixels.valid & pixels.ready;

  assign ox_inc      = offset_x + DIM_W'(1);
  assign oy_inc      = offset_y + DIM_W'(1);
  assign in_grid     = (block_column < oc) && (block_row < orr);
  assign first_pixel = (offset_x == '0) && (offset_y == '0);
  assign last_pixel  = (ox_inc >= bw) && (oy_inc >= bh);
  assign grid_last   = (block_column + COL_W'(1) == oc) && (block_row + ROW_W'(1) == orr);

  always_comb begin
    pixel_column_next = pixel_column + DIM_W'(1);
    pixel_row_next    = pixel_row;
    offset_x_next     = ox_inc;
    offset_y_next     = offset_y;
    block_column_next = block_column;
    block_row_next    = block_row;
    if (ox_inc >= bw) begin
      offset_x_next = '0;
      if (block_column < oc) begin
        block_column_next = block_column + COL_W'(1);
      end
    end
    if (pixel_column_next >= iw) begin
      pixel_column_next = '0;
      offset_x_next     = '0;
      block_column_next = '0;
      pixel_row_next    = pixel_row + DIM_W'(1);
      offset_y_next     = oy_inc;
      if (oy_inc >= bh) begin
        offset_y_next = '0;
        if (block_row < orr) begin
          block_row_next = block_row + ROW_W'(1);
        end
      end
      // end of frame
      if (pixel_row_next >= ih) begin
        pixel_row_next = '0;
        offset_y_next  = '0;
        block_row_next = '0;
      end
    end
    // a shrunk grid caps the beyond-the-grid marker
    if (block_column_next > oc) begin
      block_column_next = oc;
    end
    if (block_row_next > orr) begin
      block_row_next = orr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column <= '0;
      pixel_row    <= '0;
      offset_x     <= '0;
      offset_y     <= '0;
      block_column <= '0;
      block_row    <= '0;
    end else if (accept) begin
      pixel_column <= pixel_column_next;
      pixel_row    <= pixel_row_next;
      offset_x     <= offset_x_next;
      offset_y     <= offset_y_next;
      block_column <= block_column_next;
      block_row    <= block_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px         <= pixels.pixel;
      s1_addr       <= block_column[ADDR_W-1:0];
      s1_first      <= first_pixel;
      s1_wr         <= in_grid;
      s1_emit       <= in_grid & last_pixel;
      s1_col        <= OCW'(block_column);
      s1_row        <= ORW'(block_row);
      s1_frame_last <= grid_last;
    end
  end

  bmd_ram #(
    .WIDTH (bmd_pkg::PIXEL_W),
    .DEPTH (MAX_OUT_COLUMNS),
    .ADDR_W(ADDR_W)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_addr),
    .wdata(blk_max),
    .re   (accept),
    .raddr(block_column[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  assign ram_we  = s1_fire & s1_wr;
  assign stored  = (lw_valid && lw_addr == s1_addr) ? lw_data : ram_rdata;
  assign blk_max = (s1_first || s1_px > stored) ? s1_px : stored;

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (ram_we) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      lw_addr <= s1_addr;
      lw_data <= blk_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      res_max        <= blk_max;
      res_glyph      <= bmd_pkg::glyph_of(blk_max);
      res_col        <= s1_col;
      res_row        <= s1_row;
      res_frame_last <= s1_frame_last;
    end
  end

  assign results.valid      = res_valid;
  assign results.block_max  = res_max;
  assign results.glyph      = res_glyph;
  assign results.out_col    = res_col;
  assign results.out_row    = res_row;
  assign results.frame_last = res_frame_last;

  // the compare stage holds only behind a full, stalled result register
  `ASSERT_IMP(a_stall_only_when_full, s1_valid && !s1_fire, res_valid && !results.ready)
  // an accepted pixel always reaches the compare stage
  `ASSERT_NEXT(a_accept_enters_stage, accept, s1_valid)
  // a finished block lands in the result register with its maximum
  `ASSERT_NEXT(a_emit_lands, s1_fire && s1_emit, res_valid && res_max == $past(blk_max))
  // the bypass register tracks the latest store write
  `ASSERT_NEXT(a_bypass_tracks_write, ram_we, lw_valid && lw_data == $past(blk_max))

endmodule

`default_nettype wire

/* tb/sv/bmd_checker.sv */
// checker for the block max downscaler: watches all channels, predicts block maxima, compares
`timescale 1ns / 1ps

module bmd_checker (
  input  logic   clk,
  input  logic   rst,
  bmd_pixel_if   pixels,
  bmd_result_if  results,
  bmd_cfg_if     cfg,
  output int     mismatches,
  output int     pending,
  output int     pooled_pixels,
  output int     checked_blocks,
  output int     frames_done,
  output logic   at_frame_start
);

  localparam int unsigned DIM_CAP  = 4096;
  localparam int unsigned COLS_CAP = 1024;
  localparam int unsigned ROWS_CAP = bmd_pkg::OUT_ROWS_LIMIT;
  localparam int          SLOT_W   = $clog2(COLS_CAP);
  localparam int          REPORT_LIMIT = 10;

  localparam byte DOT_GLYPH = ".";
  localparam byte SHADES [bmd_pkg::GLYPH_ENTRIES] = '{",", ":", "o", "O", "@", "#"};

  typedef struct packed {
    bmd_pkg::pixel_t   block_max;
    bmd_pkg::glyph_t   glyph;
    bmd_pkg::out_col_t out_col;
    bmd_pkg::out_row_t out_row;
    logic              frame_last;
  } block_result_t;

  block_result_t expected_blocks [$];

  // register copies, raw as written
  logic [bmd_pkg::CFG_DATA_W-1:0]  width_reg, height_reg, blk_w_reg, blk_h_reg, rows_reg;
  logic [bmd_pkg::COLS_REG_W-1:0]  cols_reg;

  bmd_pkg::pixel_t col_max [COLS_CAP];
  int unsigned     px_col, px_row, off_x, off_y, blk_col, blk_row;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic pool_pixel(bmd_pkg::pixel_t px);
    int unsigned iw, ih, bw, bh, oc, orr;
    bmd_pkg::pixel_t m;
    logic [SLOT_W-1:0] slot;
    block_result_t r;
    iw  = clamp_dim(32'(width_reg), DIM_CAP);
    ih  = clamp_dim(32'(height_reg), DIM_CAP);
    bw  = clamp_dim(32'(blk_w_reg), DIM_CAP);
    bh  = clamp_dim(32'(blk_h_reg), DIM_CAP);
    oc  = clamp_dim(32'(cols_reg), COLS_CAP);
    orr = clamp_dim(32'(rows_reg), ROWS_CAP);

    if (blk_col < oc && blk_row < orr) begin
      pooled_pixels++;
      slot = SLOT_W'(blk_col);
      // first pixel of a block loads the column slot, later ones compare
      if (off_x == 0 && off_y == 0) begin
        m = px;
      end else begin
        m = (px > col_max[slot]) ? px : col_max[slot];
      end
      col_max[slot] = m;
      if (off_x + 1 >= bw && off_y + 1 >= bh) begin
        r.block_max  = m;
        r.glyph      = (m == 0) ? bmd_pkg::glyph_t'(DOT_GLYPH)
                                : bmd_pkg::glyph_t'(SHADES[3'(m / bmd_pkg::GLYPH_DIVISOR)]);
        r.out_col    = bmd_pkg::out_col_t'(blk_col);
        r.out_row    = bmd_pkg::out_row_t'(blk_row);
        r.frame_last = (blk_col + 1 == oc) && (blk_row + 1 == orr);
        expected_blocks.push_back(r);
      end
    end

    px_col++;
    off_x++;
    if (off_x >= bw) begin
      off_x = 0;
      if (blk_col < oc) blk_col++;
    end
    if (px_col >= iw) begin
      px_col = 0;
      off_x = 0;
      blk_col = 0;
      px_row++;
      off_y++;
      if (off_y >= bh) begin
        off_y = 0;
        if (blk_row < orr) blk_row++;
      end
      if (px_row >= ih) begin
        px_row = 0;
        off_y = 0;
        blk_row = 0;
        frames_done++;
      end
    end
    // a bound lowered mid-frame pins the block counters at the grid edge
    if (blk_col > oc) blk_col = oc;
    if (blk_row > orr) blk_row = orr;
  endtask

  always @(posedge clk) begin
    block_result_t got, want;
    if (rst) begin
      width_reg  = 13'd256;
      height_reg = 13'd256;
      blk_w_reg  = 13'd32;
      blk_h_reg  = 13'd32;
      cols_reg   = 11'd8;
      rows_reg   = 13'd8;
      px_col = 0;
      px_row = 0;
      off_x = 0;
      off_y = 0;
      blk_col = 0;
      blk_row = 0;
      foreach (col_max[k]) col_max[k] = '0;
      expected_blocks.delete();
      mismatches = 0;
      pooled_pixels = 0;
      checked_blocks = 0;
      frames_done = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          bmd_pkg::REG_IMAGE_WIDTH:  width_reg  = cfg.data;
          bmd_pkg::REG_IMAGE_HEIGHT: height_reg = cfg.data;
          bmd_pkg::REG_BLOCK_WIDTH:  blk_w_reg  = cfg.data;
          bmd_pkg::REG_BLOCK_HEIGHT: blk_h_reg  = cfg.data;
          bmd_pkg::REG_OUT_COLUMNS:  cols_reg   = cfg.data[bmd_pkg::COLS_REG_W-1:0];
          bmd_pkg::REG_OUT_ROWS:     rows_reg   = cfg.data;
          default: ;
        endcase
      end
      if (pixels.valid && pixels.ready) pool_pixel(pixels.pixel);
      if (results.valid && results.ready) begin
        got = '{results.block_max, results.glyph, results.out_col, results.out_row,
                results.frame_last};
        if (expected_blocks.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result beat with no block pending: max %0d col %0d row %0d",
                     $realtime, got.block_max, got.out_col, got.out_row);
        end else begin
          want = expected_blocks.pop_front();
          checked_blocks++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display({"%0t: block mismatch expected max %0d glyph %c col %0d row %0d last %b",
                        ", got max %0d glyph %c col %0d row %0d last %b"},
                       $realtime, want.block_max, want.glyph, want.out_col, want.out_row,
                       want.frame_last, got.block_max, got.glyph, got.out_col, got.out_row,
                       got.frame_last);
          end
        end
      end
    end
    pending = expected_blocks.size();
    at_frame_start = (px_col == 0 && px_row == 0);
  end

endmodule

/* tb/sv/block_max_downscaler_tb.sv */
// testbench top for the block max downscaler: clock, reset, pixel and register stimulus, verdict
`timescale 1ns / 1ps

module block_max_downscaler_tb;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int TARGET_PIXELS  = 1800;
  localparam int SETTLE_CYCLES  = 8;
  localparam int IDLE_PERCENT   = 6;

  typedef enum int {MOOD_DARK, MOOD_EXTREME, MOOD_MIXED} frame_mood_t;

  // glyph thresholds, zero, extremes and pixels right of and below the grid
  localparam bmd_pkg::pixel_t EDGE_FRAME [15] = '{
    8'd0,  8'd0, 8'd42, 8'd41, 8'd200,
    8'd43, 8'd1, 8'd85, 8'd86, 8'd255,
    8'd255, 8'd255, 8'd0, 8'd7, 8'd9
  };
  localparam bmd_pkg::pixel_t GLYPH_STEPS [6] = '{8'd128, 8'd129, 8'd171, 8'd172, 8'd214,
                                                  8'd215};

  logic clk;
  logic rst;
  bit   steady;
  int   cycles;
  int   sent;
  int   mismatches, pending, pooled_pixels, checked_blocks, frames_done;
  logic at_frame_start;

  bmd_pixel_if  pix_ch ();
  bmd_result_if res_ch ();
  bmd_cfg_if    cfg_ch ();

  block_max_downscaler dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  bmd_checker chk (
    .clk            (clk),
    .rst            (rst),
    .pixels         (pix_ch),
    .results        (res_ch),
    .cfg            (cfg_ch),
    .mismatches     (mismatches),
    .pending        (pending),
    .pooled_pixels  (pooled_pixels),
    .checked_blocks (checked_blocks),
    .frames_done    (frames_done),
    .at_frame_start (at_frame_start)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // result side back-pressure
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  function automatic bmd_pkg::pixel_t pick_pixel(frame_mood_t mood);
    case (mood)
      MOOD_DARK:    return bmd_pkg::pixel_t'($urandom_range(0, 1));
      MOOD_EXTREME: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      default: begin
        if ($urandom_range(0, 11) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
        return bmd_pkg::pixel_t'($urandom());
      end
    endcase
  endfunction

  function automatic int unsigned maybe_zero(int unsigned v);
    return (v == 1 && $urandom_range(0, 2) == 0) ? 0 : v;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic push_pixel(bmd_pkg::pixel_t p);
    if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= p;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(frame_mood_t mood);
    do push_pixel(pick_pixel(mood)); while (!at_frame_start);
  endtask

  // wait out every pending block plus the pipeline tail
  task automatic drain();
    pix_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(bmd_pkg::cfg_reg_t r, int unsigned v, bit more);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= bmd_pkg::cfg_data_t'(v);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    if (!more) cfg_ch.valid <= 1'b0;
  endtask

  task automatic program_grid(int unsigned iw, int unsigned ih, int unsigned bw,
                              int unsigned bh, int unsigned oc, int unsigned orr);
    write_reg(bmd_pkg::REG_IMAGE_WIDTH, iw, 1'b1);
    write_reg(bmd_pkg::REG_IMAGE_HEIGHT, ih, 1'b1);
    write_reg(bmd_pkg::REG_BLOCK_WIDTH, bw, 1'b1);
    write_reg(bmd_pkg::REG_BLOCK_HEIGHT, bh, 1'b1);
    write_reg(bmd_pkg::REG_OUT_COLUMNS, oc, 1'b1);
    write_reg(bmd_pkg::REG_OUT_ROWS, orr, 1'b0);
  endtask

  initial begin
    int          phase, nframes, rows_done, extra;
    int unsigned iw, ih, bw, bh, oc, orr;
    frame_mood_t mood;

    steady = 1'b0;
    sent = 0;
    rst = 1'b1;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 2x2 grid of 2x1 blocks inside a 5x3 image
    program_grid(5, 3, 2, 1, 2, 2);
    foreach (EDGE_FRAME[k]) push_pixel(EDGE_FRAME[k]);
    drain();

    // zero block sizes act as one, oversized column and row counts saturate
    program_grid(3, 2, 0, 0, 13'h1fff, 13'h1fff);
    foreach (GLYPH_STEPS[k]) push_pixel(GLYPH_STEPS[k]);
    drain();

    phase = 0;
    while (sent < TARGET_PIXELS) begin
      steady = (phase == 1 || phase == 2);
      case (phase)
        3: begin
          // saturated block sizes: no block of a small image completes
          program_grid(6, 2, 13'h1fff, 13'h1fff, 13'h1fff, 0);
          send_frame(MOOD_MIXED);
        end
        5: begin
          // block taller than the image never completes
          program_grid(6, 3, 2, 13'h1fff, 3, 1);
          send_frame(MOOD_MIXED);
        end
        default: begin
          bw  = $urandom_range(1, 3);
          bh  = $urandom_range(1, 3);
          oc  = $urandom_range(1, 5);
          orr = $urandom_range(1, 3);
          iw  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, bw * oc)
                                             : bw * oc + $urandom_range(0, 2);
          ih  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, bh * orr)
                                             : bh * orr + $urandom_range(0, 2);
          program_grid(maybe_zero(iw), maybe_zero(ih), maybe_zero(bw), maybe_zero(bh),
                       ($urandom_range(0, 7) == 0) ? 1024 : maybe_zero(oc),
                       ($urandom_range(0, 7) == 0) ? 4096 : maybe_zero(orr));
          nframes = $urandom_range(1, 3);
          repeat (nframes) begin
            case ($urandom_range(0, 9))
              0:       mood = MOOD_DARK;
              1:       mood = MOOD_EXTREME;
              default: mood = MOOD_MIXED;
            endcase
            send_frame(mood);
          end
          if (phase % 5 == 4) begin
            // shrink or stretch the frame height partway through a frame
            rows_done = $urandom_range(0, ih - 1);
            extra = $urandom_range(1, iw);
            repeat (rows_done * iw + extra) push_pixel(pick_pixel(MOOD_MIXED));
            drain();
            write_reg(bmd_pkg::REG_IMAGE_HEIGHT, $urandom_range(0, rows_done + 1), 1'b0);
            while (!at_frame_start) push_pixel(pick_pixel(MOOD_MIXED));
            send_frame(MOOD_MIXED);
          end
        end
      endcase
      drain();
      phase++;
    end
    steady = 1'b0;
    repeat (20) @(negedge clk);

    $display("sent %0d pixels, %0d pooled, over %0d register settings, %0d frames completed",
             sent, pooled_pixels, phase + 2, frames_done);
    $display("checked %0d block results, including zero, saturated and mid-frame settings",
             checked_blocks);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
